/* rtl/core/wtcm_pkg.sv */
// Shared widths, register indexes, codes and reset values for the wall texture column mapper.
`timescale 1ns / 1ps

package wtcm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 12;
  localparam int COORD_W    = 32;
  localparam int DIR_W      = 20;
  localparam int LH_W       = 16;
  localparam int TEXID_W    = 2;
  localparam int POS_W      = 40;
  localparam int STEP_W     = 32;
  localparam int NUM_W      = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = 2'd3;

  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [CFG_DATA_W-1:0] TEX_WIDTH_RST     = 12'd64;
  localparam logic [CFG_DATA_W-1:0] TEX_HEIGHT_RST    = 12'd64;

  localparam logic KIND_SETUP = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [TEXID_W-1:0] TEX_EAST  = 2'd0;
  localparam logic [TEXID_W-1:0] TEX_WEST  = 2'd1;
  localparam logic [TEXID_W-1:0] TEX_SOUTH = 2'd2;
  localparam logic [TEXID_W-1:0] TEX_NORTH = 2'd3;

  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

endpackage

/* rtl/core/wall_texture_column_mapper.sv */
// Raycaster wall slice mapper: column setup sequencer and per-pixel texel row stepping.
// Pixel request: result registered, out_valid rises in the cycle after accept; one pixel per
//   cycle while results are taken and no setup or rebuild runs. Setup request: no result;
//   the block is busy while the shared shift-add/shift-subtract unit does a divide, three
//   multiplies and three remainders. A tex_height write keeps it busy to rebuild the row remainders.
// Reset is synchronous, active low: registers go to 640/480/64/64, all slice state to zero.
`timescale 1ns / 1ps

module wall_texture_column_mapper #(
  parameter int FRAC_BITS = wtcm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [wtcm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [wtcm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [wtcm_pkg::PIX_W-1:0]        in_column_x,
  input  logic                              in_side,
  input  logic                              in_facing_positive,
  input  logic [wtcm_pkg::COORD_W-1:0]      in_player_coord,
  input  logic signed [wtcm_pkg::DIR_W-1:0] in_ray_dir_coord,
  input  logic [wtcm_pkg::COORD_W-1:0]      in_perp_dist,
  input  logic [wtcm_pkg::LH_W-1:0]         in_line_height,
  input  logic [wtcm_pkg::PIX_W-1:0]        in_line_start,
  input  logic [wtcm_pkg::PIX_W-1:0]        in_line_end,
  // Result requests
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wtcm_pkg::TEXID_W-1:0]      out_texture_id,
  output logic [wtcm_pkg::PIX_W-1:0]        out_texel_x,
  output logic [wtcm_pkg::PIX_W-1:0]        out_texel_y,
  output logic [wtcm_pkg::PIX_W-1:0]        out_screen_x,
  output logic [wtcm_pkg::PIX_W-1:0]        out_screen_y,
  output logic                              out_on_screen,
  output logic                              out_last
);

  import wtcm_pkg::*;

  // Derived widths. QW is the width of tex_height << FRAC_BITS, PI_W and SI_W are the
  // integer parts of the texture position and the step.
  localparam int F      = FRAC_BITS;
  localparam int FW2    = 2 * F;
  localparam int QW     = PIX_W + F;
  localparam int PI_W   = POS_W - F;
  localparam int SI_W   = STEP_W - F;
  localparam int PROD_W = STEP_W + NUM_W;
  localparam int TXP_W  = FW2 + PIX_W;
  localparam int MW1    = (FW2 > QW) ? FW2 : QW;
  localparam int MW2    = (MW1 > PI_W) ? MW1 : PI_W;
  localparam int MPL_W  = (MW2 > DIR_W) ? MW2 : DIR_W;
  localparam int ACC_W  = (TXP_W > PROD_W) ? TXP_W : PROD_W;
  localparam int CNT_W  = $clog2(MPL_W + 1);

  // The sequencer walks one setup through: step divide, start position multiply,
  // wall coordinate multiply-add, texel column multiply, then three remainders by
  // tex_height that seed the incremental texel row tracking.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NUM,
    ST_DIR,
    ST_TW,
    ST_MOD_POS,
    ST_MOD_STEP,
    ST_MOD_SAT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] sw_r, sh_r, tw_r, th_r;
  // Set by any tex_height write; the remainders are then rebuilt before the next request.
  logic                  dirty_r;

  // Slice state.
  logic [TEXID_W-1:0]    tex_sel_r;
  logic [PIX_W-1:0]      texel_col_r;
  logic [POS_W-1:0]      pos_r;
  logic [STEP_W-1:0]     step_r;
  logic [PIX_W-1:0]      row_r, end_row_r, column_r;
  // Texel row = integer part of pos_r modulo tex_height, tracked as the position advances.
  // step_mod_r is the step's integer part modulo tex_height, ty_sat_r the row of a
  // saturated position.
  logic [PIX_W-1:0]      ty_r, step_mod_r, ty_sat_r;

  // Setup operands held for the sequencer.
  logic [LH_W-1:0]       lh_r;
  logic [NUM_W-1:0]      num_r;
  logic                  num_pos_r;
  logic [COORD_W-1:0]    perp_r;
  logic signed [DIR_W-1:0] dir_r;
  logic [F-1:0]          plo_r;

  // Shared unit registers: accumulator or partial remainder, shifted multiplicand,
  // and multiplier bits or dividend bits with the quotient shifting in.
  logic [ACC_W-1:0]      acc_r;
  logic [ACC_W-1:0]      mcand_r;
  logic [MPL_W-1:0]      mpl_r;
  logic [CNT_W-1:0]      cnt_r;

  // Result register.
  logic                  out_valid_r;
  logic [TEXID_W-1:0]    out_texture_id_r;
  logic [PIX_W-1:0]      out_texel_x_r, out_texel_y_r, out_screen_x_r, out_screen_y_r;
  logic                  out_on_screen_r, out_last_r;

  // ---------------------------------------------------------------------------
  // Shared adder. In the divide and remainder states it tries a subtraction of
  // the divisor from the shifted partial remainder; in the multiply states it
  // adds the shifted multiplicand when the current multiplier bit is set.
  // ---------------------------------------------------------------------------
  logic              is_div_st;
  logic [LH_W:0]     rem_shift;
  logic [LH_W-1:0]   divisor;
  logic [ACC_W:0]    add_a, add_b, add_sum;
  logic              add_cin;
  logic              sub_ge;
  logic [LH_W-1:0]   rem_new;

  always_comb begin
    is_div_st = (state_r == ST_DIV) || (state_r == ST_MOD_POS) ||
                (state_r == ST_MOD_STEP) || (state_r == ST_MOD_SAT);
    rem_shift = {acc_r[LH_W-1:0], mpl_r[MPL_W-1]};
    divisor   = (state_r == ST_DIV) ? lh_r : LH_W'(th_r);
    if (is_div_st) begin
      add_a   = (ACC_W+1)'(rem_shift);
      add_b   = ~((ACC_W+1)'(divisor));
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, acc_r};
      add_b   = mpl_r[0] ? {1'b0, mcand_r} : '0;
      add_cin = 1'b0;
    end
    add_sum = add_a + add_b + (ACC_W+1)'(add_cin);
    sub_ge  = ~add_sum[ACC_W];
    rem_new = sub_ge ? add_sum[LH_W-1:0] : rem_shift[LH_W-1:0];
  end

  // Quotient of the step divide, saturated to the step width.
  logic [63:0]        quo64;
  logic [STEP_W-1:0]  step_sat;
  assign quo64    = 64'(mpl_r[QW-1:0]);
  assign step_sat = (quo64 > 64'(STEP_MAX)) ? STEP_MAX : quo64[STEP_W-1:0];

  // Start position: (num * step) >> 1, saturated to the position width.
  logic [POS_W-1:0]   pos_start;
  assign pos_start = (|acc_r[PROD_W-1:POS_W+1]) ? POS_MAX : acc_r[POS_W:1];

  // Texel column from the fraction times tex_width, clamped below tex_width.
  logic [PIX_W-1:0]   tx_raw, tx_clamped;
  assign tx_raw     = acc_r[TXP_W-1:FW2];
  assign tx_clamped = (tw_r == '0) ? '0 : ((tx_raw >= tw_r) ? tw_r - 1'b1 : tx_raw);

  // Setup request decode.
  logic [LH_W-1:0]    lh_eff;
  logic [NUM_W+1:0]   num_s;
  logic [TEXID_W-1:0] tex_sel_new;
  always_comb begin
    lh_eff = (in_line_height == '0) ? LH_W'(1) : in_line_height;
    num_s  = (NUM_W+2)'({in_line_start, 1'b0}) + (NUM_W+2)'(lh_eff) - (NUM_W+2)'(sh_r);
    if (in_side == 1'b0) begin
      tex_sel_new = in_facing_positive ? TEX_EAST : TEX_WEST;
    end else begin
      tex_sel_new = in_facing_positive ? TEX_SOUTH : TEX_NORTH;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel advance. The position add may saturate; otherwise the texel row moves
  // by the step's integer part plus the fraction carry, modulo tex_height. Both
  // addends are below tex_height, so one conditional subtract reduces the sum.
  // ---------------------------------------------------------------------------
  logic [POS_W:0]     pos_sum;
  logic               pos_sat;
  logic [F:0]         frac_sum;
  logic [PIX_W:0]     ty_sum, ty_red, th_ext;
  logic [PIX_W-1:0]   ty_adv;
  logic [POS_W-1:0]   pos_adv;
  logic               pix_live;
  logic               on_screen_now, last_now;

  always_comb begin
    pos_sum  = {1'b0, pos_r} + (POS_W+1)'(step_r);
    pos_sat  = pos_sum[POS_W];
    pos_adv  = pos_sat ? POS_MAX : pos_sum[POS_W-1:0];
    frac_sum = (F+1)'(pos_r[F-1:0]) + (F+1)'(step_r[F-1:0]);
    th_ext   = (PIX_W+1)'(th_r);
    ty_sum   = (PIX_W+1)'(ty_r) + (PIX_W+1)'(step_mod_r) + (PIX_W+1)'(frac_sum[F]);
    ty_red   = (ty_sum >= th_ext) ? ty_sum - th_ext : ty_sum;
    if (th_r == '0) begin
      ty_adv = '0;
    end else if (pos_sat) begin
      ty_adv = ty_sat_r;
    end else begin
      ty_adv = ty_red[PIX_W-1:0];
    end
    pix_live      = row_r < end_row_r;
    on_screen_now = (column_r < sw_r) && (row_r < sh_r);
    last_now      = ((PIX_W+1)'(row_r) + 1'b1) == (PIX_W+1)'(end_row_r);
  end

  logic in_fire, out_fire;
  assign in_ready = (state_r == ST_IDLE) && !dirty_r &&
                    ((in_kind == KIND_SETUP) || !out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SCREEN_WIDTH_RST;
      sh_r <= SCREEN_HEIGHT_RST;
      tw_r <= TEX_WIDTH_RST;
      th_r <= TEX_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SCREEN_WIDTH:  sw_r <= cfg_wdata;
        REG_SCREEN_HEIGHT: sh_r <= cfg_wdata;
        REG_TEX_WIDTH:     tw_r <= cfg_wdata;
        REG_TEX_HEIGHT:    th_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, slice state and result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
      tex_sel_r   <= '0;
      texel_col_r <= '0;
      pos_r       <= '0;
      step_r      <= '0;
      row_r       <= '0;
      end_row_r   <= '0;
      column_r    <= '0;
      ty_r        <= '0;
      step_mod_r  <= '0;
      ty_sat_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && (cfg_idx == REG_TEX_HEIGHT)) begin
        dirty_r <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_kind == KIND_SETUP)) begin
            tex_sel_r <= tex_sel_new;
            row_r     <= in_line_start;
            end_row_r <= in_line_end;
            column_r  <= in_column_x;
            lh_r      <= lh_eff;
            num_r     <= num_s[NUM_W-1:0];
            num_pos_r <= !num_s[NUM_W+1] && (num_s != '0);
            perp_r    <= in_perp_dist;
            dir_r     <= in_ray_dir_coord;
            plo_r     <= in_player_coord[F-1:0];
            // Dividend tex_height << FRAC_BITS, left-aligned in the shift register.
            acc_r     <= '0;
            mpl_r     <= MPL_W'(th_r) << (MPL_W - PIX_W);
            cnt_r     <= '0;
            state_r   <= ST_DIV;
          end else if (in_fire && pix_live) begin
            out_valid_r      <= 1'b1;
            out_texture_id_r <= tex_sel_r;
            out_texel_x_r    <= texel_col_r;
            out_texel_y_r    <= ty_r;
            out_screen_x_r   <= column_r;
            out_screen_y_r   <= row_r;
            out_on_screen_r  <= on_screen_now;
            out_last_r       <= last_now;
            pos_r            <= pos_adv;
            ty_r             <= ty_adv;
            row_r            <= row_r + 1'b1;
          end else if (dirty_r) begin
            // tex_height changed: rebuild the remainders against the new height.
            dirty_r <= cfg_we && (cfg_idx == REG_TEX_HEIGHT);
            acc_r   <= '0;
            mpl_r   <= MPL_W'(pos_r[POS_W-1:F]) << (MPL_W - PI_W);
            cnt_r   <= '0;
            state_r <= ST_MOD_POS;
          end
        end

        ST_DIV: begin
          if (cnt_r == CNT_W'(QW)) begin
            step_r  <= step_sat;
            acc_r   <= '0;
            mcand_r <= ACC_W'(step_sat);
            mpl_r   <= MPL_W'(num_r);
            cnt_r   <= '0;
            state_r <= ST_NUM;
          end else begin
            acc_r <= ACC_W'(rem_new);
            mpl_r <= {mpl_r[MPL_W-2:0], sub_ge};
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_NUM: begin
          if (cnt_r == CNT_W'(NUM_W)) begin
            pos_r   <= num_pos_r ? pos_start : '0;
            // Wall coordinate: player << FRAC_BITS plus perp * dir, kept modulo
            // 2^(2*FRAC_BITS), so only the player's fraction bits enter.
            acc_r   <= ACC_W'({plo_r, {F{1'b0}}});
            mcand_r <= ACC_W'(perp_r);
            mpl_r   <= MPL_W'(dir_r);
            cnt_r   <= '0;
            state_r <= ST_DIR;
          end else begin
            acc_r   <= add_sum[ACC_W-1:0];
            mcand_r <= mcand_r << 1;
            mpl_r   <= mpl_r >> 1;
            cnt_r   <= cnt_r + 1'b1;
          end
        end

        ST_DIR: begin
          if (cnt_r == CNT_W'(FW2)) begin
            acc_r   <= '0;
            mcand_r <= ACC_W'(acc_r[FW2-1:0]);
            mpl_r   <= MPL_W'(tw_r);
            cnt_r   <= '0;
            state_r <= ST_TW;
          end else begin
            acc_r   <= add_sum[ACC_W-1:0];
            mcand_r <= mcand_r << 1;
            mpl_r   <= mpl_r >> 1;
            cnt_r   <= cnt_r + 1'b1;
          end
        end

        ST_TW: begin
          if (cnt_r == CNT_W'(PIX_W)) begin
            texel_col_r <= tx_clamped;
            dirty_r     <= cfg_we && (cfg_idx == REG_TEX_HEIGHT);
            acc_r       <= '0;
            mpl_r       <= MPL_W'(pos_r[POS_W-1:F]) << (MPL_W - PI_W);
            cnt_r       <= '0;
            state_r     <= ST_MOD_POS;
          end else begin
            acc_r   <= add_sum[ACC_W-1:0];
            mcand_r <= mcand_r << 1;
            mpl_r   <= mpl_r >> 1;
            cnt_r   <= cnt_r + 1'b1;
          end
        end

        ST_MOD_POS: begin
          if (cnt_r == CNT_W'(PI_W)) begin
            ty_r    <= (th_r == '0) ? '0 : acc_r[PIX_W-1:0];
            acc_r   <= '0;
            mpl_r   <= MPL_W'(step_r[STEP_W-1:F]) << (MPL_W - SI_W);
            cnt_r   <= '0;
            state_r <= ST_MOD_STEP;
          end else begin
            acc_r <= ACC_W'(rem_new);
            mpl_r <= {mpl_r[MPL_W-2:0], sub_ge};
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_MOD_STEP: begin
          if (cnt_r == CNT_W'(SI_W)) begin
            step_mod_r <= (th_r == '0) ? '0 : acc_r[PIX_W-1:0];
            acc_r      <= '0;
            mpl_r      <= {MPL_W{1'b1}} << (MPL_W - PI_W);
            cnt_r      <= '0;
            state_r    <= ST_MOD_SAT;
          end else begin
            acc_r <= ACC_W'(rem_new);
            mpl_r <= {mpl_r[MPL_W-2:0], sub_ge};
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_MOD_SAT: begin
          if (cnt_r == CNT_W'(PI_W)) begin
            ty_sat_r <= (th_r == '0) ? '0 : acc_r[PIX_W-1:0];
            state_r  <= ST_IDLE;
          end else begin
            acc_r <= ACC_W'(rem_new);
            mpl_r <= {mpl_r[MPL_W-2:0], sub_ge};
            cnt_r <= cnt_r + 1'b1;
          end
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_texture_id = out_texture_id_r;
  assign out_texel_x    = out_texel_x_r;
  assign out_texel_y    = out_texel_y_r;
  assign out_screen_x   = out_screen_x_r;
  assign out_screen_y   = out_screen_y_r;
  assign out_on_screen  = out_on_screen_r;
  assign out_last       = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // While the sequencer is busy no new result may appear.
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && (state_r != ST_IDLE)) |=> !out_valid_r)
    else $error("result appeared while the setup sequencer was busy");

  // Once the remainders are current, the tracked texel rows stay below tex_height.
  a_rows_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && !dirty_r && (th_r != '0)) |->
      ((ty_r < th_r) && (step_mod_r < th_r) && (ty_sat_r < th_r)))
    else $error("texel row tracking not reduced modulo tex_height");

  // A setup request always starts the step divide.
  a_setup_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_SETUP)) |=> (state_r == ST_DIV))
    else $error("setup request did not start the divide");

endmodule

/* test/wall_texture_column_mapper_tb.sv */
// Self-checking testbench for the wall texture column mapper, with a scoreboard class and drivers.
`timescale 1ns / 1ps

module wall_texture_column_mapper_tb;
  import wtcm_pkg::*;

  localparam int FRAC          = FRAC_BITS_DEF;
  // SETTLE_CYCLES quiet cycles outlast a column setup and a tex_height rebuild, so the
  // block is idle before the registers are touched.
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS   = 10;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int PHASE_QUOTA   = 225;

  // One input request as it appears on the in_ ports.
  typedef struct packed {
    logic               kind;
    logic [PIX_W-1:0]   column_x;
    logic               side;
    logic               facing_positive;
    logic [COORD_W-1:0] player_coord;
    logic [DIR_W-1:0]   ray_dir_coord;
    logic [COORD_W-1:0] perp_dist;
    logic [LH_W-1:0]    line_height;
    logic [PIX_W-1:0]   line_start;
    logic [PIX_W-1:0]   line_end;
  } column_req_t;

  // One pixel result as it appears on the out_ ports.
  typedef struct packed {
    logic [TEXID_W-1:0] texture_id;
    logic [PIX_W-1:0]   texel_x;
    logic [PIX_W-1:0]   texel_y;
    logic [PIX_W-1:0]   screen_x;
    logic [PIX_W-1:0]   screen_y;
    logic               on_screen;
    logic               last;
  } texel_t;

  // The scoreboard keeps its own copy of the registers and the slice state, works
  // out the texel each pixel request should produce and matches results in order.
  class texel_scoreboard;
    logic [PIX_W-1:0]   screen_w, screen_h, tex_w, tex_h;
    logic [TEXID_W-1:0] tex_sel;
    logic [PIX_W-1:0]   tex_col, row, end_row, col;
    logic [63:0]        pos, step;
    texel_t             expected_q[$];
    int                 fail_cnt;

    function new();
      screen_w = SCREEN_WIDTH_RST;
      screen_h = SCREEN_HEIGHT_RST;
      tex_w    = TEX_WIDTH_RST;
      tex_h    = TEX_HEIGHT_RST;
      tex_sel  = '0;
      tex_col  = '0;
      row      = '0;
      end_row  = '0;
      col      = '0;
      pos      = '0;
      step     = '0;
      fail_cnt = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  screen_w = val;
        REG_SCREEN_HEIGHT: screen_h = val;
        REG_TEX_WIDTH:     tex_w = val;
        REG_TEX_HEIGHT:    tex_h = val;
        default: ;
      endcase
    endfunction

    // Returns 1 when the request produces a pixel result.
    function bit note_request(column_req_t r);
      texel_t      want;
      logic [63:0] lh, quo, prod, wall, dir_ext, tx, ty, next_pos;
      longint      num, start_v, height_v, lh_v;
      if (r.kind == KIND_SETUP) begin
        if (r.side == 1'b0) tex_sel = r.facing_positive ? TEX_EAST : TEX_WEST;
        else tex_sel = r.facing_positive ? TEX_SOUTH : TEX_NORTH;
        // A zero height slice is stepped as if it were one row tall.
        lh = (r.line_height == '0) ? 64'd1 : 64'(r.line_height);
        quo = (64'(tex_h) << FRAC) / lh;
        step = (quo > 64'(STEP_MAX)) ? 64'(STEP_MAX) : quo;
        // The wall top sits at screen_h/2 - lh/2, kept exact by doubling.
        start_v = longint'(r.line_start);
        height_v = longint'(screen_h);
        lh_v = lh;
        num = 2 * start_v - height_v + lh_v;
        if (num <= 0) begin
          pos = '0;
        end else begin
          prod = (64'(num) * step) >> 1;
          pos = (prod > 64'(POS_MAX)) ? 64'(POS_MAX) : prod;
        end
        // The hit coordinate carries twice the fraction bits; its fraction wraps
        // into [0,1) even when the sum is negative.
        dir_ext = {{(64-DIR_W){r.ray_dir_coord[DIR_W-1]}}, r.ray_dir_coord};
        wall = (64'(r.player_coord) << FRAC) + 64'(r.perp_dist) * dir_ext;
        wall = wall & ((64'd1 << (2 * FRAC)) - 64'd1);
        tx = (wall * 64'(tex_w)) >> (2 * FRAC);
        if (tex_w == '0) tx = '0;
        else if (tx >= 64'(tex_w)) tx = 64'(tex_w) - 64'd1;
        tex_col = tx[PIX_W-1:0];
        row = r.line_start;
        end_row = r.line_end;
        col = r.column_x;
        return 1'b0;
      end
      // A finished or empty slice swallows the pixel request.
      if (row >= end_row) return 1'b0;
      ty = (tex_h == '0) ? 64'd0 : ((pos >> FRAC) % 64'(tex_h));
      want.texture_id = tex_sel;
      want.texel_x = tex_col;
      want.texel_y = ty[PIX_W-1:0];
      want.screen_x = col;
      want.screen_y = row;
      want.on_screen = (col < screen_w) && (row < screen_h);
      want.last = (({1'b0, row} + 13'd1) == {1'b0, end_row});
      expected_q.push_back(want);
      next_pos = pos + step;
      pos = (next_pos > 64'(POS_MAX)) ? 64'(POS_MAX) : next_pos;
      row = row + 1'b1;
      return 1'b1;
    endfunction

    function string show(texel_t t);
      return $sformatf("tex=%0d u=%0d v=%0d x=%0d y=%0d vis=%0b last=%0b",
                       t.texture_id, t.texel_x, t.texel_y, t.screen_x, t.screen_y,
                       t.on_screen, t.last);
    endfunction

    function void check_result(texel_t got);
      texel_t want;
      if (expected_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: texel result with nothing pending: %s", $time, show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.texture_id !== want.texture_id || got.texel_x !== want.texel_x ||
          got.texel_y !== want.texel_y || got.screen_x !== want.screen_x ||
          got.screen_y !== want.screen_y || got.on_screen !== want.on_screen ||
          got.last !== want.last) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: texel mismatch\n  expected %s\n  actual   %s",
                   $time, show(want), show(got));
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                 in_valid, in_ready;
  logic                 in_kind, in_side, in_facing_positive;
  logic [PIX_W-1:0]     in_column_x, in_line_start, in_line_end;
  logic [COORD_W-1:0]   in_player_coord, in_perp_dist;
  logic signed [DIR_W-1:0] in_ray_dir_coord;
  logic [LH_W-1:0]      in_line_height;
  logic                 out_valid, out_ready;
  logic [TEXID_W-1:0]   out_texture_id;
  logic [PIX_W-1:0]     out_texel_x, out_texel_y, out_screen_x, out_screen_y;
  logic                 out_on_screen, out_last;

  texel_scoreboard sb;
  int useful_reqs = 0;
  int send_burst = 0;
  int recv_burst = 0;
  int cycle_cnt = 0;

  wall_texture_column_mapper #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_column_x(in_column_x), .in_side(in_side), .in_facing_positive(in_facing_positive),
    .in_player_coord(in_player_coord), .in_ray_dir_coord(in_ray_dir_coord),
    .in_perp_dist(in_perp_dist), .in_line_height(in_line_height),
    .in_line_start(in_line_start), .in_line_end(in_line_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_texture_id(out_texture_id),
    .out_texel_x(out_texel_x), .out_texel_y(out_texel_y), .out_screen_x(out_screen_x),
    .out_screen_y(out_screen_y), .out_on_screen(out_on_screen), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both sides draw a random wait before each request. Now and then a burst
  // of back-to-back requests with no waiting at all is thrown in.
  function automatic int draw_gap(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst_left = int'($urandom_range(10, 60));
      return 0;
    end
    return int'($urandom_range(0, 12));
  endfunction

  // Every field random, setup kind. Pixel requests reuse it, since the block
  // ignores everything but the kind on a pixel request.
  function automatic column_req_t random_setup();
    column_req_t r;
    r.kind = KIND_SETUP;
    r.column_x = PIX_W'($urandom);
    r.side = 1'($urandom_range(0, 1));
    r.facing_positive = 1'($urandom_range(0, 1));
    r.player_coord = $urandom;
    r.ray_dir_coord = DIR_W'($urandom);
    r.perp_dist = $urandom;
    r.line_height = LH_W'($urandom);
    r.line_start = PIX_W'($urandom);
    r.line_end = PIX_W'($urandom);
    return r;
  endfunction

  function automatic column_req_t random_pixel();
    column_req_t r;
    r = random_setup();
    r.kind = KIND_PIXEL;
    return r;
  endfunction

  function automatic column_req_t setup_req(logic [PIX_W-1:0] column_x, logic side,
                                            logic facing, logic [COORD_W-1:0] player,
                                            logic [DIR_W-1:0] dir, logic [COORD_W-1:0] perp,
                                            logic [LH_W-1:0] lh, logic [PIX_W-1:0] first_row,
                                            logic [PIX_W-1:0] stop_row);
    column_req_t r;
    r.kind = KIND_SETUP;
    r.column_x = column_x;
    r.side = side;
    r.facing_positive = facing;
    r.player_coord = player;
    r.ray_dir_coord = dir;
    r.perp_dist = perp;
    r.line_height = lh;
    r.line_start = first_row;
    r.line_end = stop_row;
    return r;
  endfunction

  // Drives one input request and returns at the rising edge where it is taken.
  // With no wait drawn, valid simply stays high and only the payload changes,
  // so valid never gets two updates in one time step.
  task automatic send_request(column_req_t r);
    int gap;
    bit produced;
    gap = draw_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind <= r.kind;
    in_column_x <= r.column_x;
    in_side <= r.side;
    in_facing_positive <= r.facing_positive;
    in_player_coord <= r.player_coord;
    in_ray_dir_coord <= r.ray_dir_coord;
    in_perp_dist <= r.perp_dist;
    in_line_height <= r.line_height;
    in_line_start <= r.line_start;
    in_line_end <= r.line_end;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    produced = sb.note_request(r);
    // Pixel requests past the end of a slice do no work and are not counted.
    if (produced || r.kind == KIND_SETUP) useful_reqs++;
  endtask

  // Drops valid and holds the sender back until every pending result is out.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // A setup produces no result, so an empty scoreboard does not mean the block
  // is idle; the extra quiet cycles cover a setup still in progress.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.note_config(idx, val);
    @(negedge clk);
  endtask

  // The texture height goes last, so the rebuild it starts inside the block
  // never overlaps another register write.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] sh,
                                logic [CFG_DATA_W-1:0] tw, logic [CFG_DATA_W-1:0] th);
    settle();
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_TEX_WIDTH, tw);
    write_reg(REG_TEX_HEIGHT, th);
    cfg_we <= 1'b0;
  endtask

  // Known cases under the reset register values.
  task automatic run_directed();
    // A pixel request before any column setup sees an empty slice.
    send_request(random_pixel());
    // East wall, hit exactly half way across the texel row, three rows, then
    // one more pixel request against the finished slice.
    send_request(setup_req(12'd0, 1'b0, 1'b1, 32'h0001_8000, 20'h00000, 32'h0000_0000,
                           16'd480, 12'd0, 12'd3));
    repeat (4) send_request(random_pixel());
    // West wall: top values, most negative ray direction, zero line height, empty slice.
    send_request(setup_req(12'hFFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 20'h80000, 32'hFFFF_FFFF,
                           16'd0, 12'hFFF, 12'hFFF));
    send_request(random_pixel());
    // South wall crossing the bottom of the display, tallest slice.
    send_request(setup_req(12'd639, 1'b1, 1'b1, 32'h0000_0000, 20'h7FFFF, 32'h0000_FFFF,
                           16'hFFFF, 12'd479, 12'd482));
    repeat (3) send_request(random_pixel());
    hold_until_drained();
    // North wall just off the right edge, with the start position below zero.
    send_request(setup_req(12'd640, 1'b1, 1'b0, 32'h1234_5678, 20'hFFFFF, 32'h0001_0000,
                           16'd1, 12'd10, 12'd12));
    repeat (2) send_request(random_pixel());
    // A one row slice at the bottom of the row range, far down the texture.
    send_request(setup_req(12'd100, 1'b0, 1'b1, $urandom, 20'h0ABCD, $urandom,
                           16'd2, 12'd4094, 12'd4095));
    send_request(random_pixel());
  endtask

  // Mostly complete slices (a setup and then one pixel request per row) with
  // random content. The rest are slices cut short by the next setup, overruns
  // past the last row, unstructured setups and pixels, and drain pauses.
  task automatic run_traffic(int quota);
    int done_at, kind_sel, len, stop, rows;
    column_req_t r;
    done_at = useful_reqs + quota;
    while (useful_reqs < done_at) begin
      kind_sel = int'($urandom_range(0, 99));
      if (kind_sel < 4) begin
        hold_until_drained();
      end else if (kind_sel < 74) begin
        r = random_setup();
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(25, 300)) :
                                            int'($urandom_range(1, 24));
        stop = int'(r.line_start) + len;
        if (stop > 4095) stop = 4095;
        r.line_end = PIX_W'(stop);
        if ($urandom_range(0, 3) == 0) r.line_height = LH_W'($urandom_range(0, 64));
        send_request(r);
        rows = stop - int'(r.line_start);
        if ($urandom_range(0, 4) == 0) rows = int'($urandom_range(0, rows));
        else rows = rows + int'($urandom_range(0, 2));
        repeat (rows) send_request(random_pixel());
      end else if (kind_sel < 92) begin
        send_request(random_setup());
        repeat ($urandom_range(0, 6)) send_request(random_pixel());
      end else begin
        send_request(random_pixel());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_SETUP;
    in_column_x = '0;
    in_side = 1'b0;
    in_facing_positive = 1'b0;
    in_player_coord = '0;
    in_ray_dir_coord = '0;
    in_perp_dist = '0;
    in_line_height = '0;
    in_line_start = '0;
    in_line_end = '0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_traffic(PHASE_QUOTA);
    // Register extremes first, including zero texture sizes, then ordinary and
    // random settings.
    apply_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    run_traffic(PHASE_QUOTA);
    apply_settings(12'd1, 12'd1, 12'd1, 12'd1);
    run_traffic(PHASE_QUOTA);
    apply_settings(12'd0, 12'd0, 12'd0, 12'd0);
    run_traffic(PHASE_QUOTA);
    apply_settings(12'd320, 12'd200, 12'd128, 12'd100);
    run_traffic(PHASE_QUOTA);
    repeat (3) begin
      apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      run_traffic(PHASE_QUOTA);
    end

    settle();
    if (sb.outstanding() != 0) begin
      $display("%0d texel results never arrived", sb.outstanding());
      sb.fail_cnt++;
    end
    if (sb.fail_cnt == 0) begin
      $display("[wall_texture_column_mapper] OK");
    end else begin
      $display("[wall_texture_column_mapper] ERROR");
    end
    $finish;
  end

  // Result side: ready is held back at random, and each result is taken at the
  // rising edge where valid and ready are both high.
  initial begin : result_sink
    texel_t got;
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(recv_burst);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.texture_id = out_texture_id;
      got.texel_x = out_texel_x;
      got.texel_y = out_texel_y;
      got.screen_x = out_screen_x;
      got.screen_y = out_screen_y;
      got.on_screen = out_on_screen;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  // The limit is several times the slowest correct run, so a hang ends the run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[wall_texture_column_mapper] ERROR");
      $finish;
    end
  end

endmodule
